/* design/blt_pkg.sv */
// Shared types and constants for the bounded ordered list.
`timescale 1ns / 1ps
`default_nettype none

package blt_pkg;

  localparam int unsigned POS_W    = 5;
  localparam int unsigned CAP_W    = 5;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned WORD_W   = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [POS_W-1:0] pos;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* design/bounded_ordered_list.sv */
// Bounded ordered list with insert, remove, read and clear built on a row of cells.
// A result is registered on the edge that accepts its item.
// Throughput: one item per cycle while the input is not stalled; every cell shifts its entry in the same edge.
// The input stalls only while a finished result waits and the output is stalled.
// Reset empties the list, sets the capacity to 16 and drops any pending result.
// Entries themselves are not cleared by reset and are read only once written.
`timescale 1ns / 1ps
`default_nettype none

module bounded_ordered_list #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [4:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_opcode,
  input  wire logic [4:0] in_position,
  input  wire logic [31:0] in_item_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_status,
  output logic [31:0]     out_read_data,
  output logic [4:0]      out_entry_count,
  output logic            out_is_full,
  output logic            out_is_empty
);

  localparam int unsigned SW = (DATA_WIDTH < blt_pkg::WORD_W) ? DATA_WIDTH : blt_pkg::WORD_W;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > blt_pkg::POS_W) ? CW : blt_pkg::POS_W;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

  logic [blt_pkg::CAP_W-1:0]   cap_r;
  logic [CW-1:0]               cnt_r;
  logic [CW-1:0]               cnt_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [1:0]                  out_status_r;
  logic [31:0]                 out_read_data_r;
  logic [blt_pkg::COUNT_W-1:0] out_entry_count_r;
  logic                        out_is_full_r;
  logic                        out_is_empty_r;

  logic                        in_acc;
  blt_pkg::opcode_t            op;
  blt_pkg::status_t            status;
  blt_pkg::cell_ctl_t          ctl;
  logic [XW-1:0]               pos_x;
  logic [XW-1:0]               cnt_x;
  logic [XW-1:0]               cnt_nxt_x;
  logic [XW-1:0]               cap_x;
  logic [XW-1:0]               eff_cap_x;
  logic [SW-1:0]               item_word;
  logic [SW-1:0]               rd_sel;
  logic [31:0]                 rdata;
  logic [SW-1:0]               cell_word [DEPTH];

  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign op        = blt_pkg::opcode_t'(in_opcode);
  assign pos_x     = XW'(in_position);
  assign cnt_x     = XW'(cnt_r);
  assign cap_x     = XW'(cap_r);
  assign eff_cap_x = (cap_x > DEPTH_X) ? DEPTH_X : cap_x;
  assign item_word = in_item_data[SW-1:0];
  assign cnt_nxt_x = XW'(cnt_nxt);

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (XW'(i) == pos_x) begin
        rd_sel = cell_word[i];
      end
    end
  end

  always_comb begin
    status  = blt_pkg::ST_OK;
    cnt_nxt = cnt_r;
    rdata   = '0;
    ctl.ins = 1'b0;
    ctl.rem = 1'b0;
    ctl.pos = in_position;
    case (op)
      blt_pkg::OP_INSERT: begin
        if (pos_x > cnt_x) begin
          status = blt_pkg::ST_BOUNDS;
        end else if ((cnt_x >= eff_cap_x) || (cnt_x >= DEPTH_X)) begin
          status = blt_pkg::ST_FULL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          ctl.ins = in_acc;
        end
      end
      blt_pkg::OP_REMOVE: begin
        if (cnt_r == '0) begin
          status = blt_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status = blt_pkg::ST_BOUNDS;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
          ctl.rem = in_acc;
        end
      end
      blt_pkg::OP_READ: begin
        if (pos_x >= cnt_x) begin
          status = blt_pkg::ST_BOUNDS;
        end else begin
          rdata = 32'(rd_sel);
        end
      end
      blt_pkg::OP_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        status = blt_pkg::ST_OK;
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [SW-1:0] left_w;
    logic [SW-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = item_word;
    end else begin : g_left
      assign left_w = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_word[g];
    end else begin : g_right
      assign right_w = cell_word[g+1];
    end
    blt_cell #(
      .IDX     (g),
      .WORD_BW (SW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .item_word  (item_word),
      .left_word  (left_w),
      .right_word (right_w),
      .word_o     (cell_word[g])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= blt_pkg::CAP_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (in_acc) begin
        cnt_r <= cnt_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_status_r      <= status;
      out_read_data_r   <= rdata;
      out_entry_count_r <= blt_pkg::COUNT_W'(cnt_nxt);
      out_is_full_r     <= (cnt_nxt_x >= eff_cap_x);
      out_is_empty_r    <= (cnt_nxt == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_data   = out_read_data_r;
  assign out_entry_count = out_entry_count_r;
  assign out_is_full     = out_is_full_r;
  assign out_is_empty    = out_is_empty_r;

`ifndef ASSERT_OFF
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_x <= DEPTH_X)
    else $error("entry count exceeds list depth");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted item produced no result");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && ctl.ins) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("successful insert did not grow the list by one");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (op == blt_pkg::OP_CLEAR)) |=> (cnt_r == '0) && out_is_empty_r)
    else $error("clear did not empty the list");
`endif

endmodule

`default_nettype wire

/* design/blt_cell.sv */
// One list cell that holds an entry and shifts it to or from its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module blt_cell #(
  parameter int unsigned IDX     = 0,
  parameter int unsigned WORD_BW = 32
) (
  input  wire logic               clk,
  input  wire blt_pkg::cell_ctl_t ctl,
  input  wire logic [WORD_BW-1:0] item_word,
  input  wire logic [WORD_BW-1:0] left_word,
  input  wire logic [WORD_BW-1:0] right_word,
  output logic      [WORD_BW-1:0] word_o
);

  localparam logic [31:0] IDX_V = 32'(IDX);

  logic [WORD_BW-1:0] data_r;
  logic [WORD_BW-1:0] data_nxt;
  logic [31:0]        pos_w;

  assign pos_w = 32'(ctl.pos);

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (IDX_V > pos_w) begin
        data_nxt = left_word;
      end else if (IDX_V == pos_w) begin
        data_nxt = item_word;
      end
    end else if (ctl.rem && (IDX_V >= pos_w)) begin
      data_nxt = right_word;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign word_o = data_r;

endmodule

`default_nettype wire

/* test/list_checker.sv */
// Checker that predicts and compares every result of the bounded ordered list.
`timescale 1ns / 1ps

module list_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [blt_pkg::CAP_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic [blt_pkg::POS_W-1:0]  in_position,
  input  logic [blt_pkg::WORD_W-1:0] in_item_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [1:0]                 out_status,
  input  logic [blt_pkg::WORD_W-1:0] out_read_data,
  input  logic [blt_pkg::COUNT_W-1:0] out_entry_count,
  input  logic                       out_is_full,
  input  logic                       out_is_empty,
  output int                         mismatch_count,
  output int                         pending_count,
  output int                         list_level
);

  localparam int unsigned SLOTS = 16;

  typedef struct packed {
    blt_pkg::status_t                status;
    logic [blt_pkg::WORD_W-1:0]      rdata;
    logic [blt_pkg::COUNT_W-1:0]     count;
    logic                            full;
    logic                            empty;
  } reply_t;

  logic [blt_pkg::WORD_W-1:0] shadow_list [SLOTS];
  int                         shadow_fill;
  logic [blt_pkg::CAP_W-1:0]  shadow_cap;
  reply_t                     expected_replies [$];
  int                         errors;

  function automatic reply_t apply_request(blt_pkg::opcode_t op,
                                           logic [blt_pkg::POS_W-1:0] pos,
                                           logic [blt_pkg::WORD_W-1:0] word);
    reply_t r;
    int     limit;
    int     i;
    limit = (shadow_cap > SLOTS) ? SLOTS : int'(shadow_cap);
    r = '0;
    r.status = blt_pkg::ST_OK;
    case (op)
      blt_pkg::OP_INSERT: begin
        if (pos > shadow_fill) begin
          r.status = blt_pkg::ST_BOUNDS;
        end else if (shadow_fill >= limit) begin
          r.status = blt_pkg::ST_FULL;
        end else begin
          for (i = shadow_fill; i > pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = word;
          shadow_fill++;
        end
      end
      blt_pkg::OP_REMOVE: begin
        if (shadow_fill == 0) begin
          r.status = blt_pkg::ST_EMPTY;
        end else if (pos >= shadow_fill) begin
          r.status = blt_pkg::ST_BOUNDS;
        end else begin
          for (i = pos; i + 1 < shadow_fill; i++) shadow_list[i] = shadow_list[i+1];
          shadow_fill--;
        end
      end
      blt_pkg::OP_READ: begin
        if (pos >= shadow_fill) r.status = blt_pkg::ST_BOUNDS;
        else r.rdata = shadow_list[pos];
      end
      default: begin
        shadow_fill = 0;
      end
    endcase
    r.count = shadow_fill[blt_pkg::COUNT_W-1:0];
    r.full  = (shadow_fill >= limit);
    r.empty = (shadow_fill == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst_n) begin
      shadow_fill = 0;
      shadow_cap  = blt_pkg::CAP_RESET;
      expected_replies.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en) shadow_cap = cfg_wr_data;
      if (in_valid && !in_stall) begin
        expected_replies.push_back(apply_request(blt_pkg::opcode_t'(in_opcode), in_position,
                                                 in_item_data));
      end
      if (out_valid && !out_stall) begin
        got.status = blt_pkg::status_t'(out_status);
        got.rdata  = out_read_data;
        got.count  = out_entry_count;
        got.full   = out_is_full;
        got.empty  = out_is_empty;
        if (expected_replies.size() == 0) begin
          errors++;
          if (errors <= 10) $display("[%0t] result arrived with no item pending", $time);
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status || got.rdata !== want.rdata ||
              got.count !== want.count || got.full !== want.full ||
              got.empty !== want.empty) begin
            errors++;
            if (errors <= 10) begin
              $display("[%0t] mismatch: expected status %0d data %h count %0d full %b empty %b",
                       $time, want.status, want.rdata, want.count, want.full, want.empty);
              $display("[%0t]           got      status %0d data %h count %0d full %b empty %b",
                       $time, got.status, got.rdata, got.count, got.full, got.empty);
            end
          end
        end
      end
    end
    mismatch_count <= errors;
    pending_count  <= expected_replies.size();
    list_level     <= shadow_fill;
  end

endmodule

/* test/bounded_ordered_list_tb.sv */
// Testbench top for the bounded ordered list: stimulus, stalls and the verdict.
`timescale 1ns / 1ps

module bounded_ordered_list_tb;

  localparam int RANDOM_ITEMS = 1400;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_wr_en = 1'b0;
  logic [blt_pkg::CAP_W-1:0]   cfg_wr_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [1:0]                  in_opcode = blt_pkg::OP_READ;
  logic [blt_pkg::POS_W-1:0]   in_position = '0;
  logic [blt_pkg::WORD_W-1:0]  in_item_data = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [1:0]                  out_status;
  logic [blt_pkg::WORD_W-1:0]  out_read_data;
  logic [blt_pkg::COUNT_W-1:0] out_entry_count;
  logic                        out_is_full;
  logic                        out_is_empty;

  int mismatch_count;
  int pending_count;
  int list_level;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_timer = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bounded_ordered_list dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_position(in_position), .in_item_data(in_item_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_read_data(out_read_data),
    .out_entry_count(out_entry_count), .out_is_full(out_is_full),
    .out_is_empty(out_is_empty)
  );

  list_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_position(in_position), .in_item_data(in_item_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_read_data(out_read_data),
    .out_entry_count(out_entry_count), .out_is_full(out_is_full),
    .out_is_empty(out_is_empty),
    .mismatch_count(mismatch_count), .pending_count(pending_count),
    .list_level(list_level)
  );

  always @(negedge clk) begin
    if (stall_timer == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      stall_timer <= $urandom_range(20, 120);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= (stall_timer % 7 < 3);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  task automatic send_request(blt_pkg::opcode_t op, logic [blt_pkg::POS_W-1:0] pos,
                              logic [blt_pkg::WORD_W-1:0] word);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_position  <= pos;
    in_item_data <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_capacity(logic [blt_pkg::CAP_W-1:0] cap);
    wait_for_results();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic fill_to(int n);
    int i;
    for (i = 0; i < n; i++) begin
      send_request(blt_pkg::OP_INSERT, blt_pkg::POS_W'($urandom_range(0, i)), $urandom);
    end
  endtask

  function automatic logic [blt_pkg::WORD_W-1:0] random_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request();
    int                        pick;
    int                        level;
    blt_pkg::opcode_t          op;
    logic [blt_pkg::POS_W-1:0] pos;
    level = list_level;
    pick = $urandom_range(0, 99);
    if (pick < 40) op = blt_pkg::OP_INSERT;
    else if (pick < 68) op = blt_pkg::OP_REMOVE;
    else if (pick < 96) op = blt_pkg::OP_READ;
    else op = blt_pkg::OP_CLEAR;
    pick = $urandom_range(0, 99);
    if (pick < 75) pos = blt_pkg::POS_W'($urandom_range(0, level));
    else if (pick < 95) pos = blt_pkg::POS_W'($urandom_range(0, 16));
    else pos = blt_pkg::POS_W'($urandom_range(0, 31));
    send_request(op, pos, random_word());
  endtask

  initial begin
    logic [blt_pkg::CAP_W-1:0] caps [12];
    int p;
    int k;
    caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd7, 5'd3, 5'd16, 5'd12, 5'd2, 5'd17, 5'd5, 5'd16};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_request(blt_pkg::OP_REMOVE, 5'd0, 32'h0);
    send_request(blt_pkg::OP_REMOVE, 5'd31, 32'hFFFF_FFFF);
    send_request(blt_pkg::OP_READ, 5'd0, 32'h0);
    send_request(blt_pkg::OP_INSERT, 5'd1, 32'h1234_5678);
    send_request(blt_pkg::OP_INSERT, 5'd0, 32'hFFFF_FFFF);
    send_request(blt_pkg::OP_INSERT, 5'd0, 32'h0000_0000);
    send_request(blt_pkg::OP_INSERT, 5'd2, 32'hA5A5_A5A5);
    send_request(blt_pkg::OP_INSERT, 5'd1, 32'h5A5A_5A5A);
    send_request(blt_pkg::OP_READ, 5'd0, 32'h0);
    send_request(blt_pkg::OP_READ, 5'd1, 32'h0);
    send_request(blt_pkg::OP_READ, 5'd3, 32'h0);
    send_request(blt_pkg::OP_READ, 5'd4, 32'h0);
    send_request(blt_pkg::OP_READ, 5'd31, 32'h0);
    send_request(blt_pkg::OP_REMOVE, 5'd4, 32'h0);
    send_request(blt_pkg::OP_REMOVE, 5'd1, 32'h0);
    send_request(blt_pkg::OP_INSERT, 5'd31, 32'h0);
    send_request(blt_pkg::OP_READ, 5'd1, 32'h0);
    send_request(blt_pkg::OP_CLEAR, 5'd0, 32'h0);
    send_request(blt_pkg::OP_CLEAR, 5'd31, 32'h0);

    // The list holds five entries when the capacity drops to three.
    fill_to(5);
    set_capacity(5'd3);
    send_request(blt_pkg::OP_INSERT, 5'd0, 32'hDEAD_BEEF);
    send_request(blt_pkg::OP_INSERT, 5'd9, 32'h0);
    send_request(blt_pkg::OP_REMOVE, 5'd4, 32'h0);
    send_request(blt_pkg::OP_REMOVE, 5'd0, 32'h0);
    send_request(blt_pkg::OP_REMOVE, 5'd1, 32'h0);
    send_request(blt_pkg::OP_INSERT, 5'd2, 32'hCAFE_F00D);
    send_request(blt_pkg::OP_CLEAR, 5'd0, 32'h0);

    set_capacity(5'd0);
    send_request(blt_pkg::OP_INSERT, 5'd0, 32'h1);
    send_request(blt_pkg::OP_INSERT, 5'd1, 32'h1);
    send_request(blt_pkg::OP_READ, 5'd0, 32'h0);

    set_capacity(5'd31);
    fill_to(16);
    send_request(blt_pkg::OP_INSERT, 5'd16, 32'h2);
    send_request(blt_pkg::OP_READ, 5'd15, 32'h0);
    send_request(blt_pkg::OP_READ, 5'd16, 32'h0);
    send_request(blt_pkg::OP_REMOVE, 5'd15, 32'h0);

    for (p = 0; p < 12; p++) begin
      set_capacity(caps[p]);
      for (k = 0; k < RANDOM_ITEMS / 12; k++) begin
        random_request();
        if ($urandom_range(0, 99) == 0) wait_for_results();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    k = 0;
    @(posedge clk);
    while (pending_count != 0 && k < 5000) begin
      @(posedge clk);
      k++;
    end
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
